// ===== rtl/kmcp_pkg.sv =====
// Shared types and constants for the weighted k-means colour palette block.
package kmcp_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 32;
  localparam int MIN_CLUSTERS = 14;
  localparam int FRAC_BITS    = 8;

  localparam int PT_AW  = $clog2(MAX_POINTS);
  localparam int CNT_W  = PT_AW + 1;
  localparam int CL_W   = $clog2(MAX_CLUSTERS);
  localparam int K_W    = CL_W + 1;
  localparam int ASG_W  = K_W;
  localparam int CH_W   = 8;
  localparam int COL_W  = 3 * CH_W;
  localparam int CTR_W  = CH_W + FRAC_BITS;
  localparam int CWD_W  = 3 * CTR_W;
  localparam int W_W    = 20;
  localparam int PIX_W  = W_W + PT_AW;
  localparam int ACC_W  = CH_W + W_W + PT_AW;
  localparam int DIST_W = 2 * CTR_W + 4;
  localparam int PK_W   = CNT_W + K_W;
  localparam int TGT_W  = 6;
  localparam int PASS_W = 16;
  localparam int OCI_W  = 5;
  localparam int MEMB_W = 11;
  localparam int OPIX_W = 30;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_TARGET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd1;

  localparam logic [TGT_W-1:0]  TARGET_RESET = 6'd14;
  localparam logic [PASS_W-1:0] LIMIT_RESET  = 16'd20;

  // assignment code for a colour that belongs to no cluster yet
  localparam logic [ASG_W-1:0] ASG_NONE = {ASG_W{1'b1}};

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [W_W-1:0]  pixel_weight;
    logic            last_point;
  } in_item_t;

  typedef struct packed {
    logic [OCI_W-1:0]  cluster_index;
    logic [CH_W-1:0]   center_red;
    logic [CH_W-1:0]   center_green;
    logic [CH_W-1:0]   center_blue;
    logic [MEMB_W-1:0] member_points;
    logic [OPIX_W-1:0] member_pixels;
    logic              last_cluster;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear_run;
    logic prep;
    logic init_step;
    logic pass_start;
    logic dist_step;
    logic dist_cmp;
    logic asn_write;
    logic gth_start;
    logic gth_step;
    logic div_start;
    logic div_take;
    logic ctr_write;
    logic clus_first;
    logic clus_next;
    logic pass_end;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic p_last;
    logic ci_last;
    logic comp_last;
    logic pass_done;
    logic moved;
    logic pix_zero;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/kmcp_div.sv =====
// Restoring divider: one quotient bit per cycle, for the weighted centre mean.
module kmcp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [kmcp_pkg::PIX_W-1:0] num_hi,
  input  logic [kmcp_pkg::CTR_W-1:0] num_lo,
  input  logic [kmcp_pkg::PIX_W-1:0] den,
  output logic                       done,
  output logic [kmcp_pkg::CTR_W-1:0] quo
);
  import kmcp_pkg::*;

  localparam int STEP_W = $clog2(CTR_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PIX_W-1:0]  rem_r, rem_nxt;
  logic [PIX_W-1:0]  den_r, den_nxt;
  logic [CTR_W-1:0]  lo_r, lo_nxt;
  logic [CTR_W-1:0]  q_r, q_nxt;
  logic [PIX_W:0]    trial;
  logic [PIX_W:0]    diff;
  logic              ge;

  // num_hi < den is guaranteed, so the quotient fits in CTR_W bits
  always_comb begin
    trial    = {rem_r, lo_r[CTR_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = num_hi;
      den_nxt  = den;
      lo_nxt   = num_lo;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
      lo_nxt   = {lo_r[CTR_W-2:0], 1'b0};
      q_nxt    = {q_r[CTR_W-2:0], ge};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(CTR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    lo_r   <= lo_nxt;
    q_r    <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== rtl/kmcp_dp.sv =====
// Datapath: colour, weight, assignment and centre memories, distance and mean units.
module kmcp_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kmcp_pkg::cmd_t                  cmd,
  output kmcp_pkg::stat_t                 stat,
  input  kmcp_pkg::in_item_t              in_data,
  input  logic                            cfg_we,
  input  logic [kmcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmcp_pkg::CFG_DATA_W-1:0] cfg_data,
  output kmcp_pkg::out_item_t             out_data
);
  import kmcp_pkg::*;

  localparam logic [1:0] COMP_RED   = 2'd0;
  localparam logic [1:0] COMP_GREEN = 2'd1;
  localparam logic [1:0] COMP_BLUE  = 2'd2;

  function automatic logic [CH_W-1:0] colour_byte(input logic [COL_W-1:0] col,
                                                  input logic [1:0] comp);
    logic [CH_W-1:0] b;
    unique case (comp)
      COMP_RED:   b = col[3*CH_W-1:2*CH_W];
      COMP_GREEN: b = col[2*CH_W-1:CH_W];
      default:    b = col[CH_W-1:0];
    endcase
    return b;
  endfunction

  function automatic logic [CTR_W-1:0] centre_part(input logic [CWD_W-1:0] w,
                                                   input logic [1:0] comp);
    logic [CTR_W-1:0] c;
    unique case (comp)
      COMP_RED:   c = w[3*CTR_W-1:2*CTR_W];
      COMP_GREEN: c = w[2*CTR_W-1:CTR_W];
      default:    c = w[CTR_W-1:0];
    endcase
    return c;
  endfunction

  // memories
  logic [COL_W-1:0] colour_mem [MAX_POINTS];
  logic [W_W-1:0]   weight_mem [MAX_POINTS];
  logic [ASG_W-1:0] asg_mem    [MAX_POINTS];
  logic [CWD_W-1:0] ctr_mem    [MAX_CLUSTERS];
  logic [COL_W-1:0] colour_rd;
  logic [W_W-1:0]   weight_rd;
  logic [ASG_W-1:0] asg_rd;
  logic [CWD_W-1:0] ctr_rd;

  logic [TGT_W-1:0]  tgt_r, tgt_nxt;
  logic [PASS_W-1:0] lim_r, lim_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [PT_AW-1:0]  p_r, p_nxt;
  logic [CL_W-1:0]   ci_r, ci_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic [K_W-1:0]    inext_r, inext_nxt;
  logic [PK_W-1:0]   inn_r, inn_nxt;
  logic [PK_W-1:0]   pk_r, pk_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic              moved_r, moved_nxt;
  logic              first_r, first_nxt;
  logic [CL_W-1:0]   best_r, best_nxt;
  logic [DIST_W-1:0] bestd_r, bestd_nxt;
  logic [DIST_W-1:0] dsum_r, dsum_nxt;
  logic [CNT_W-1:0]  memb_r, memb_nxt;
  logic [PIX_W-1:0]  pix_r, pix_nxt;
  logic [ACC_W-1:0]  acc_r [3];
  logic [ACC_W-1:0]  acc_nxt [3];
  logic [CTR_W-1:0]  newc_r [3];
  logic [CTR_W-1:0]  newc_nxt [3];
  out_item_t         out_r, out_nxt;

  logic              pt_we;
  logic              asg_we;
  logic [ASG_W-1:0]  asg_wd;
  logic              ctr_we;
  logic [CL_W-1:0]   ctr_wa;
  logic [CWD_W-1:0]  ctr_wd;
  logic [CNT_W-1:0]  tgt_lo;
  logic [CNT_W-1:0]  k_calc;
  logic              hit;
  logic [CTR_W-1:0]  pt_fix;
  logic [CTR_W-1:0]  ctr_q;
  logic [CTR_W-1:0]  dabs;
  logic [2*CTR_W-1:0] sq;
  logic [DIST_W-1:0] wsq;
  logic              match;
  logic [CH_W+W_W-1:0] prod [3];
  logic              div_done;
  logic [CTR_W-1:0]  div_quo;
  logic [ACC_W-1:0]  div_num;

  // cluster count: target raised to the minimum, capped by colours and storage
  always_comb begin
    tgt_lo = (tgt_r < TGT_W'(MIN_CLUSTERS)) ? CNT_W'(MIN_CLUSTERS) : CNT_W'(tgt_r);
    k_calc = (tgt_lo < cnt_r) ? tgt_lo : cnt_r;
    if (k_calc > CNT_W'(MAX_CLUSTERS)) k_calc = CNT_W'(MAX_CLUSTERS);
  end

  // colour p starts cluster inext when floor(inext*n/k) == p
  assign hit = (inext_r < k_r) && (inn_r < pk_r + PK_W'(k_r));

  // one squared, weighted channel difference per cycle
  always_comb begin
    pt_fix = {colour_byte(colour_rd, comp_r), {FRAC_BITS{1'b0}}};
    ctr_q  = centre_part(ctr_rd, comp_r);
    dabs   = (pt_fix > ctr_q) ? (pt_fix - ctr_q) : (ctr_q - pt_fix);
    sq     = dabs * dabs;
    unique case (comp_r)
      COMP_RED:   wsq = {3'b000, sq, 1'b0};
      COMP_GREEN: wsq = {2'b00, sq, 2'b00};
      default:    wsq = {3'b000, sq, 1'b0} + {4'b0000, sq};
    endcase
  end

  assign match = (asg_rd == {1'b0, ci_r});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = colour_byte(colour_rd, 2'(c)) * weight_rd;
    end
  end

  always_comb begin
    unique case (comp_r)
      COMP_RED:   div_num = acc_r[0];
      COMP_GREEN: div_num = acc_r[1];
      default:    div_num = acc_r[2];
    endcase
  end

  kmcp_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num_hi (div_num[ACC_W-1:CH_W]),
    .num_lo ({div_num[CH_W-1:0], {FRAC_BITS{1'b0}}}),
    .den    (pix_r),
    .done   (div_done),
    .quo    (div_quo)
  );

  always_comb begin
    tgt_nxt   = tgt_r;
    lim_nxt   = lim_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    ci_nxt    = ci_r;
    comp_nxt  = comp_r;
    inext_nxt = inext_r;
    inn_nxt   = inn_r;
    pk_nxt    = pk_r;
    pass_nxt  = pass_r;
    moved_nxt = moved_r;
    first_nxt = first_r;
    best_nxt  = best_r;
    bestd_nxt = bestd_r;
    dsum_nxt  = dsum_r;
    memb_nxt  = memb_r;
    pix_nxt   = pix_r;
    acc_nxt   = acc_r;
    newc_nxt  = newc_r;
    out_nxt   = out_r;
    pt_we     = 1'b0;
    asg_we    = 1'b0;
    asg_wd    = ASG_NONE;
    ctr_we    = 1'b0;
    ctr_wa    = ci_r;
    ctr_wd    = {newc_r[0], newc_r[1], newc_r[2]};

    if (cfg_we) begin
      if (cfg_index == CFG_CLUSTER_TARGET) tgt_nxt = cfg_data[TGT_W-1:0];
      if (cfg_index == CFG_ITERATION_LIMIT) lim_nxt = cfg_data[PASS_W-1:0];
    end

    if (cmd.load && (cnt_r < CNT_W'(MAX_POINTS))) begin
      pt_we   = 1'b1;
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (cmd.clear_run) cnt_nxt = '0;

    if (cmd.prep) begin
      k_nxt     = K_W'(k_calc);
      p_nxt     = '0;
      inext_nxt = '0;
      inn_nxt   = '0;
      pk_nxt    = '0;
      pass_nxt  = '0;
    end

    if (cmd.init_step) begin
      asg_we = 1'b1;
      asg_wd = hit ? inext_r : ASG_NONE;
      if (hit) begin
        ctr_we    = 1'b1;
        ctr_wa    = inext_r[CL_W-1:0];
        ctr_wd    = {colour_rd[3*CH_W-1:2*CH_W], {FRAC_BITS{1'b0}},
                     colour_rd[2*CH_W-1:CH_W], {FRAC_BITS{1'b0}},
                     colour_rd[CH_W-1:0], {FRAC_BITS{1'b0}}};
        inext_nxt = inext_r + K_W'(1);
        inn_nxt   = inn_r + PK_W'(cnt_r);
      end
      pk_nxt = pk_r + PK_W'(k_r);
      p_nxt  = p_r + PT_AW'(1);
    end

    if (cmd.pass_start) begin
      p_nxt     = '0;
      ci_nxt    = '0;
      comp_nxt  = '0;
      moved_nxt = 1'b0;
      first_nxt = 1'b1;
      dsum_nxt  = '0;
    end

    if (cmd.dist_step) begin
      dsum_nxt = dsum_r + wsq;
      comp_nxt = comp_r + 2'd1;
    end

    if (cmd.dist_cmp) begin
      if (first_r || (dsum_r < bestd_r)) begin
        best_nxt  = ci_r;
        bestd_nxt = dsum_r;
      end
      first_nxt = 1'b0;
      dsum_nxt  = '0;
      comp_nxt  = '0;
      ci_nxt    = ci_r + CL_W'(1);
    end

    if (cmd.asn_write) begin
      asg_we = 1'b1;
      asg_wd = {1'b0, best_r};
      if (asg_rd != {1'b0, best_r}) moved_nxt = 1'b1;
      p_nxt     = p_r + PT_AW'(1);
      ci_nxt    = '0;
      first_nxt = 1'b1;
    end

    if (cmd.clus_first) ci_nxt = '0;
    if (cmd.clus_next) ci_nxt = ci_r + CL_W'(1);

    if (cmd.gth_start) begin
      p_nxt    = '0;
      comp_nxt = '0;
      memb_nxt = '0;
      pix_nxt  = '0;
      for (int c = 0; c < 3; c++) acc_nxt[c] = '0;
    end

    if (cmd.gth_step) begin
      if (match) begin
        memb_nxt = memb_r + CNT_W'(1);
        pix_nxt  = pix_r + PIX_W'(weight_rd);
        for (int c = 0; c < 3; c++) acc_nxt[c] = acc_r[c] + ACC_W'(prod[c]);
      end
      p_nxt = p_r + PT_AW'(1);
    end

    if (cmd.div_take) begin
      unique case (comp_r)
        COMP_RED:   newc_nxt[0] = div_quo;
        COMP_GREEN: newc_nxt[1] = div_quo;
        default:    newc_nxt[2] = div_quo;
      endcase
      comp_nxt = comp_r + 2'd1;
    end

    if (cmd.ctr_write) ctr_we = 1'b1;

    if (cmd.pass_end) pass_nxt = pass_r + PASS_W'(1);

    if (cmd.out_load) begin
      out_nxt.cluster_index = OCI_W'(ci_r);
      out_nxt.center_red    = ctr_rd[3*CTR_W-1 -: CH_W];
      out_nxt.center_green  = ctr_rd[2*CTR_W-1 -: CH_W];
      out_nxt.center_blue   = ctr_rd[CTR_W-1 -: CH_W];
      out_nxt.member_points = MEMB_W'(memb_r);
      out_nxt.member_pixels = OPIX_W'(pix_r);
      out_nxt.last_cluster  = stat.ci_last;
    end
  end

  always_comb begin
    stat.p_last    = ({1'b0, p_r} == cnt_r - CNT_W'(1));
    stat.ci_last   = ({1'b0, ci_r} == k_r - K_W'(1));
    stat.comp_last = (comp_r == COMP_BLUE);
    stat.pass_done = (pass_r == lim_r);
    stat.moved     = moved_r;
    stat.pix_zero  = (pix_r == '0);
    stat.div_done  = div_done;
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      colour_mem[cnt_r[PT_AW-1:0]] <= {in_data.red, in_data.green, in_data.blue};
      weight_mem[cnt_r[PT_AW-1:0]] <= in_data.pixel_weight;
    end
    colour_rd <= colour_mem[p_r];
    weight_rd <= weight_mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (asg_we) asg_mem[p_r] <= asg_wd;
    asg_rd <= asg_mem[p_r];
  end

  always_ff @(posedge clk) begin
    if (ctr_we) ctr_mem[ctr_wa] <= ctr_wd;
    ctr_rd <= ctr_mem[ci_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= TARGET_RESET;
      lim_r <= LIMIT_RESET;
      cnt_r <= '0;
    end else begin
      tgt_r <= tgt_nxt;
      lim_r <= lim_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    p_r     <= p_nxt;
    ci_r    <= ci_nxt;
    comp_r  <= comp_nxt;
    inext_r <= inext_nxt;
    inn_r   <= inn_nxt;
    pk_r    <= pk_nxt;
    pass_r  <= pass_nxt;
    moved_r <= moved_nxt;
    first_r <= first_nxt;
    best_r  <= best_nxt;
    bestd_r <= bestd_nxt;
    dsum_r  <= dsum_nxt;
    memb_r  <= memb_nxt;
    pix_r   <= pix_nxt;
    acc_r   <= acc_nxt;
    newc_r  <= newc_nxt;
    out_r   <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ===== rtl/kmcp_ctrl.sv =====
// Sequencer: loading, start-up sweep, assignment and update passes, result output.
module kmcp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  input  logic            out_ready,
  input  kmcp_pkg::stat_t stat,
  output kmcp_pkg::cmd_t  cmd,
  output logic            in_ready,
  output logic            out_valid
);
  import kmcp_pkg::*;

  typedef enum logic [17:0] {
    S_LOAD      = 18'b000000000000000001,
    S_PREP      = 18'b000000000000000010,
    S_INIT_WAIT = 18'b000000000000000100,
    S_INIT_STEP = 18'b000000000000001000,
    S_PASS_CHK  = 18'b000000000000010000,
    S_ASN_WAIT  = 18'b000000000000100000,
    S_ASN_DIST  = 18'b000000000001000000,
    S_ASN_CMP   = 18'b000000000010000000,
    S_ASN_WR    = 18'b000000000100000000,
    S_GTH_WAIT  = 18'b000000001000000000,
    S_GTH_ACC   = 18'b000000010000000000,
    S_GTH_END   = 18'b000000100000000000,
    S_DIV_GO    = 18'b000001000000000000,
    S_DIV_WAIT  = 18'b000010000000000000,
    S_CTR_WR    = 18'b000100000000000000,
    S_NEXT_CLUS = 18'b001000000000000000,
    S_PASS_END  = 18'b010000000000000000,
    S_EMIT      = 18'b100000000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   final_r, final_nxt;

  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_INIT_WAIT;
      end
      S_INIT_WAIT: state_nxt = S_INIT_STEP;
      S_INIT_STEP: begin
        cmd.init_step = 1'b1;
        state_nxt     = stat.p_last ? S_PASS_CHK : S_INIT_WAIT;
      end
      S_PASS_CHK: begin
        if (stat.pass_done) begin
          cmd.clus_first = 1'b1;
          cmd.gth_start  = 1'b1;
          final_nxt      = 1'b1;
          state_nxt      = S_GTH_WAIT;
        end else begin
          cmd.pass_start = 1'b1;
          state_nxt      = S_ASN_WAIT;
        end
      end
      S_ASN_WAIT: state_nxt = S_ASN_DIST;
      S_ASN_DIST: begin
        cmd.dist_step = 1'b1;
        if (stat.comp_last) state_nxt = S_ASN_CMP;
      end
      S_ASN_CMP: begin
        cmd.dist_cmp = 1'b1;
        state_nxt    = stat.ci_last ? S_ASN_WR : S_ASN_WAIT;
      end
      S_ASN_WR: begin
        cmd.asn_write = 1'b1;
        if (stat.p_last) begin
          cmd.clus_first = 1'b1;
          cmd.gth_start  = 1'b1;
          state_nxt      = S_GTH_WAIT;
        end else begin
          state_nxt = S_ASN_WAIT;
        end
      end
      S_GTH_WAIT: state_nxt = S_GTH_ACC;
      S_GTH_ACC: begin
        cmd.gth_step = 1'b1;
        state_nxt    = stat.p_last ? S_GTH_END : S_GTH_WAIT;
      end
      S_GTH_END: begin
        if (final_r) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_EMIT;
        end else if (stat.pix_zero) begin
          state_nxt = S_NEXT_CLUS;
        end else begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = stat.comp_last ? S_CTR_WR : S_DIV_GO;
        end
      end
      S_CTR_WR: begin
        cmd.ctr_write = 1'b1;
        state_nxt     = S_NEXT_CLUS;
      end
      S_NEXT_CLUS: begin
        if (stat.ci_last) begin
          state_nxt = S_PASS_END;
        end else begin
          cmd.clus_next = 1'b1;
          cmd.gth_start = 1'b1;
          state_nxt     = S_GTH_WAIT;
        end
      end
      S_PASS_END: begin
        cmd.pass_end = 1'b1;
        if (stat.moved) begin
          state_nxt = S_PASS_CHK;
        end else begin
          // converged: report from the current assignment
          cmd.clus_first = 1'b1;
          cmd.gth_start  = 1'b1;
          final_nxt      = 1'b1;
          state_nxt      = S_GTH_WAIT;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.ci_last) begin
            cmd.clear_run = 1'b1;
            final_nxt     = 1'b0;
            state_nxt     = S_LOAD;
          end else begin
            cmd.clus_next = 1'b1;
            cmd.gth_start = 1'b1;
            state_nxt     = S_GTH_WAIT;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
    end
  end

endmodule

// ===== rtl/weighted_kmeans_colour_palette_top.sv =====
// Top level of the weighted k-means colour palette block.
// Colours are taken one request per cycle while loading (up to 1024 are stored, later
// ones are dropped). The request marked last_point starts clustering on the n stored
// colours with k clusters, and no request is taken until the last result is delivered.
// Start-up sweeps the stored colours once to seed the centres. Each pass assigns every
// colour to its nearest centre (one squarer handles one colour channel of one centre
// per cycle), then, per cluster, sums the weighted colours of its members and, for a
// cluster with pixels, forms each channel of the centre mean on the bit-serial divider
// and stores the centre; pass control follows. Each output cluster follows a sweep over
// its members, and a result waits on out_ready.
module weighted_kmeans_colour_palette_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  kmcp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output kmcp_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [kmcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmcp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kmcp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  kmcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_point),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  kmcp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/kmcp_checker.sv =====
// Port-level checks for the palette block, bound to the top level.
module kmcp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input kmcp_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input kmcp_pkg::out_item_t             out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("loading and result output at once");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_point |=> !in_ready)
    else $error("request taken after last colour");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_cluster |=> in_ready && !out_valid)
    else $error("no return to loading after final cluster");

  a_next_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_cluster |=> !out_valid && !in_ready)
    else $error("next cluster shown without its member sweep");

endmodule

bind weighted_kmeans_colour_palette_top kmcp_checker u_kmcp_checker (.*);
